// ===== design/assert_macros.svh =====
// Assertion macros included by the RTL top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);
`define ASSERT_NEVER(lbl, ck, rs, cond, msg) \
  `ASSERT_PROP(lbl, ck, rs, !(cond), msg)
`else
`define ASSERT_PROP(lbl, ck, rs, prop, msg)
`define ASSERT_NEVER(lbl, ck, rs, cond, msg)
`endif

`endif

// ===== design/lfu_pkg.sv =====
// Shared types and constants of the LFU replacement block
`default_nettype none

package lfu_pkg;

  localparam int DEF_MAX_ENTRIES = 256;
  localparam int DEF_COUNT_BITS  = 32;
  localparam int CHUNK_W         = 64;
  localparam int STAMP_W         = 48;
  localparam int CAP_W           = 9;
  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-3:0] REG_CAPACITY = '0;

  localparam logic REQ_STORE = 1'b1;

  typedef struct packed {
    logic               req_type;
    logic [CHUNK_W-1:0] chunk_id;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic               evicted;
    logic [CHUNK_W-1:0] evicted_chunk;
    logic               full_res;
  } res_t;

  typedef struct packed {
    logic hit;
    logic sat;
    logic best_v;
    logic free_v;
  } scan_flags_t;

  typedef struct packed {
    logic inv_en;
    logic fill_en;
  } pend_ctl_t;

endpackage

`default_nettype wire

// ===== design/lfu_cell.sv =====
// One storage cell of the rotating entry ring
`default_nettype none

module lfu_cell import lfu_pkg::*; #(
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  shift,
  input  wire logic                  in_valid,
  input  wire logic [CHUNK_W-1:0]    in_chunk,
  input  wire logic [COUNT_BITS-1:0] in_count,
  input  wire logic [STAMP_W-1:0]    in_stamp,
  output logic                       valid,
  output logic [CHUNK_W-1:0]         chunk,
  output logic [COUNT_BITS-1:0]      count,
  output logic [STAMP_W-1:0]         stamp
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (shift) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      chunk <= in_chunk;
      count <= in_count;
      stamp <= in_stamp;
    end
  end

endmodule

`default_nettype wire

// ===== design/lfu_scan.sv =====
// Head unit of the ring: pending writes, hit update, victim and free-slot tracking
`default_nettype none

module lfu_scan import lfu_pkg::*; #(
  parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
  parameter int COUNT_BITS  = DEF_COUNT_BITS,
  localparam int SLOT_W     = $clog2(MAX_ENTRIES)
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  clear,
  input  wire logic                  en,
  input  wire logic [SLOT_W-1:0]     pos,
  input  wire logic [CHUNK_W-1:0]    key,
  input  wire logic [STAMP_W-1:0]    cur_stamp,
  input  wire pend_ctl_t             pend,
  input  wire logic [SLOT_W-1:0]     inv_slot,
  input  wire logic [SLOT_W-1:0]     fill_slot,
  input  wire logic [CHUNK_W-1:0]    fill_chunk,
  input  wire logic [STAMP_W-1:0]    fill_stamp,
  input  wire logic                  head_valid,
  input  wire logic [CHUNK_W-1:0]    head_chunk,
  input  wire logic [COUNT_BITS-1:0] head_count,
  input  wire logic [STAMP_W-1:0]    head_stamp,
  output logic                       tail_valid,
  output logic [CHUNK_W-1:0]         tail_chunk,
  output logic [COUNT_BITS-1:0]      tail_count,
  output logic [STAMP_W-1:0]         tail_stamp,
  output scan_flags_t                flags,
  output logic [SLOT_W-1:0]          best_slot,
  output logic [COUNT_BITS-1:0]      best_count,
  output logic [STAMP_W-1:0]         best_stamp,
  output logic [CHUNK_W-1:0]         best_chunk,
  output logic [SLOT_W-1:0]          free_slot
);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  logic                  e_valid;
  logic [CHUNK_W-1:0]    e_chunk;
  logic [COUNT_BITS-1:0] e_count;
  logic [STAMP_W-1:0]    e_stamp;
  logic                  match;
  logic                  at_max;
  logic                  better;
  logic                  take_free;

  always_comb begin
    e_valid = head_valid;
    e_chunk = head_chunk;
    e_count = head_count;
    e_stamp = head_stamp;
    if (pend.fill_en && pos == fill_slot) begin
      e_valid = 1'b1;
      e_chunk = fill_chunk;
      e_count = '0;
      e_stamp = fill_stamp;
    end else if (pend.inv_en && pos == inv_slot) begin
      e_valid = 1'b0;
    end

    match  = e_valid && (e_chunk == key);
    at_max = (e_count == COUNT_MAX);

    tail_valid = e_valid;
    tail_chunk = e_chunk;
    tail_count = e_count;
    tail_stamp = e_stamp;
    if (match && !at_max) begin
      tail_count = e_count + 1'b1;
      tail_stamp = cur_stamp;
    end

    better = tail_valid && (!flags.best_v || (tail_count < best_count) ||
             ((tail_count == best_count) && (tail_stamp < best_stamp)));
    take_free = !tail_valid && !flags.free_v;
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      flags <= '0;
    end else if (en) begin
      if (match) begin
        flags.hit <= 1'b1;
        flags.sat <= at_max;
      end
      if (better) begin
        flags.best_v <= 1'b1;
      end
      if (take_free) begin
        flags.free_v <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (better) begin
        best_slot  <= pos;
        best_count <= tail_count;
        best_stamp <= tail_stamp;
        best_chunk <= tail_chunk;
      end
      if (take_free) begin
        free_slot <= pos;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/lfu_cache_replacement.sv =====
// Top level of the LFU replacement block: entry ring, head unit, control, register port
//
//   channel   handshake            payload          direction
//   request   start / busy         req   (req_t)    in
//   result    done (1-cycle)       res   (res_t)    out
//   config    psel/penable/pwrite  paddr, pwdata    in, prdata out
//
// An item is taken in the idle state; then the entry ring rotates once past the head unit,
// one slot per scan step, and a decide step ends it with the result.
// The rotation of the cell ring sets the length of an item; each item sees every slot once.
// rst clears valid bits, occupancy, stamp counter and pending writes;
// capacity returns to 256. No clearing pass.
// The result is on res for the single cycle that done is high; start may be taken
// in that same cycle. The receiver cannot stall.
`default_nettype none

module lfu_cache_replacement import lfu_pkg::*; #(
  parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
  parameter int COUNT_BITS  = DEF_COUNT_BITS
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire req_t               req,
  output logic                    done,
  output res_t                    res,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0]      prdata,
  output logic                    pready
);

`include "assert_macros.svh"

  localparam int SLOT_W = $clog2(MAX_ENTRIES);
  localparam int OCC_W  = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W  = (OCC_W > CAP_W) ? OCC_W : CAP_W;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAX_ENTRIES - 1);
  localparam logic [OCC_W-1:0]  OCC_FULL  = OCC_W'(MAX_ENTRIES);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DECIDE} state_t;

  state_t              state;
  logic [SLOT_W-1:0]   pos;
  req_t                req_q;
  logic [OCC_W-1:0]    occupancy;
  logic [STAMP_W-1:0]  next_stamp;
  logic [CAP_W-1:0]    capacity;
  pend_ctl_t           pend;
  logic [SLOT_W-1:0]   inv_slot;
  logic [SLOT_W-1:0]   fill_slot;
  logic [CHUNK_W-1:0]  fill_chunk;
  logic [STAMP_W-1:0]  fill_stamp;

  logic                  cell_valid [MAX_ENTRIES];
  logic [CHUNK_W-1:0]    cell_chunk [MAX_ENTRIES];
  logic [COUNT_BITS-1:0] cell_count [MAX_ENTRIES];
  logic [STAMP_W-1:0]    cell_stamp [MAX_ENTRIES];
  logic                  nxt_valid  [MAX_ENTRIES];
  logic [CHUNK_W-1:0]    nxt_chunk  [MAX_ENTRIES];
  logic [COUNT_BITS-1:0] nxt_count  [MAX_ENTRIES];
  logic [STAMP_W-1:0]    nxt_stamp  [MAX_ENTRIES];

  logic                  tail_valid;
  logic [CHUNK_W-1:0]    tail_chunk;
  logic [COUNT_BITS-1:0] tail_count;
  logic [STAMP_W-1:0]    tail_stamp;
  scan_flags_t           flags;
  logic [SLOT_W-1:0]     best_slot;
  logic [COUNT_BITS-1:0] best_count;
  logic [STAMP_W-1:0]    best_stamp;
  logic [CHUNK_W-1:0]    best_chunk;
  logic [SLOT_W-1:0]     free_slot;

  logic                  scan_clear;
  logic                  scan_en;

  res_t                  res_next;
  logic [OCC_W-1:0]      occ_next;
  logic [STAMP_W-1:0]    stamp_next;
  logic [STAMP_W-1:0]    stamp0;
  pend_ctl_t             pend_next;
  logic [SLOT_W-1:0]     inv_slot_next;
  logic [SLOT_W-1:0]     fill_slot_next;
  logic                  new_low;
  logic [CMP_W-1:0]      cap_x;

  assign busy       = (state != ST_IDLE);
  assign scan_clear = (state == ST_IDLE) && start;
  assign scan_en    = (state == ST_SCAN);
  assign pready     = 1'b1;
  assign prdata     = (paddr[PADDR_W-1:2] == REG_CAPACITY) ? PDATA_W'(capacity) : '0;
  assign cap_x      = CMP_W'(capacity);

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_ring
    if (i == MAX_ENTRIES - 1) begin : g_last
      assign nxt_valid[i] = tail_valid;
      assign nxt_chunk[i] = tail_chunk;
      assign nxt_count[i] = tail_count;
      assign nxt_stamp[i] = tail_stamp;
    end else begin : g_mid
      assign nxt_valid[i] = cell_valid[i+1];
      assign nxt_chunk[i] = cell_chunk[i+1];
      assign nxt_count[i] = cell_count[i+1];
      assign nxt_stamp[i] = cell_stamp[i+1];
    end

    lfu_cell #(.COUNT_BITS(COUNT_BITS)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .shift    (scan_en),
      .in_valid (nxt_valid[i]),
      .in_chunk (nxt_chunk[i]),
      .in_count (nxt_count[i]),
      .in_stamp (nxt_stamp[i]),
      .valid    (cell_valid[i]),
      .chunk    (cell_chunk[i]),
      .count    (cell_count[i]),
      .stamp    (cell_stamp[i])
    );
  end

  lfu_scan #(.MAX_ENTRIES(MAX_ENTRIES), .COUNT_BITS(COUNT_BITS)) u_scan (
    .clk        (clk),
    .rst        (rst),
    .clear      (scan_clear),
    .en         (scan_en),
    .pos        (pos),
    .key        (req_q.chunk_id),
    .cur_stamp  (next_stamp),
    .pend       (pend),
    .inv_slot   (inv_slot),
    .fill_slot  (fill_slot),
    .fill_chunk (fill_chunk),
    .fill_stamp (fill_stamp),
    .head_valid (cell_valid[0]),
    .head_chunk (cell_chunk[0]),
    .head_count (cell_count[0]),
    .head_stamp (cell_stamp[0]),
    .tail_valid (tail_valid),
    .tail_chunk (tail_chunk),
    .tail_count (tail_count),
    .tail_stamp (tail_stamp),
    .flags      (flags),
    .best_slot  (best_slot),
    .best_count (best_count),
    .best_stamp (best_stamp),
    .best_chunk (best_chunk),
    .free_slot  (free_slot)
  );

  always_comb begin
    stamp0         = (flags.hit && !flags.sat) ? next_stamp + 1'b1 : next_stamp;
    stamp_next     = stamp0;
    occ_next       = occupancy;
    pend_next      = '0;
    inv_slot_next  = best_slot;
    fill_slot_next = free_slot;
    res_next       = '0;
    res_next.hit   = flags.hit;
    new_low        = !flags.best_v || (best_count != '0) || (stamp0 < best_stamp) ||
                     ((stamp0 == best_stamp) && (free_slot < best_slot));

    if (req_q.req_type == REQ_STORE) begin
      if (flags.hit) begin
        if (CMP_W'(occupancy) > cap_x) begin
          res_next.evicted       = 1'b1;
          res_next.evicted_chunk = best_chunk;
          pend_next.inv_en       = 1'b1;
          occ_next               = occupancy - 1'b1;
        end
      end else if (occupancy == OCC_FULL) begin
        stamp_next       = stamp0 + 1'b1;
        res_next.evicted = 1'b1;
        if (flags.best_v && best_count == '0) begin
          res_next.evicted_chunk = best_chunk;
          pend_next.fill_en      = 1'b1;
          fill_slot_next         = best_slot;
        end else begin
          res_next.evicted_chunk = req_q.chunk_id;
        end
      end else begin
        stamp_next = stamp0 + 1'b1;
        if (CMP_W'(occupancy) + 1'b1 > cap_x) begin
          res_next.evicted = 1'b1;
          if (new_low) begin
            res_next.evicted_chunk = req_q.chunk_id;
          end else begin
            res_next.evicted_chunk = best_chunk;
            pend_next.inv_en       = 1'b1;
            pend_next.fill_en      = 1'b1;
          end
        end else begin
          pend_next.fill_en = 1'b1;
          occ_next          = occupancy + 1'b1;
        end
      end
    end

    res_next.full_res = (CMP_W'(occ_next) >= cap_x);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      pos        <= '0;
      done       <= 1'b0;
      occupancy  <= '0;
      next_stamp <= '0;
      pend       <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_SCAN;
            pos   <= '0;
            req_q <= req;
          end
        end
        ST_SCAN: begin
          pos <= pos + 1'b1;
          if (pos == LAST_SLOT) begin
            state <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          state      <= ST_IDLE;
          done       <= 1'b1;
          res        <= res_next;
          occupancy  <= occ_next;
          next_stamp <= stamp_next;
          pend       <= pend_next;
          inv_slot   <= inv_slot_next;
          fill_slot  <= fill_slot_next;
          fill_chunk <= req_q.chunk_id;
          fill_stamp <= stamp0;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (psel && penable && pwrite && paddr[PADDR_W-1:2] == REG_CAPACITY) begin
      capacity <= pwdata[CAP_W-1:0];
    end
  end

  `ASSERT_PROP(a_done_after_decide, clk, rst, done |-> $past(state == ST_DECIDE), "result strobe without decide step")
  `ASSERT_PROP(a_scan_length, clk, rst, (state == ST_SCAN && pos == LAST_SLOT) |=> (state == ST_DECIDE), "ring scan did not end after one rotation")
  `ASSERT_PROP(a_occ_bound, clk, rst, occupancy <= OCC_FULL, "occupancy above slot count")
  `ASSERT_PROP(a_evict_on_store, clk, rst, (done && res.evicted) |-> (req_q.req_type == REQ_STORE), "lookup evicted an entry")
  `ASSERT_NEVER(a_pend_overlap, clk, rst, pend.inv_en && pend.fill_en && inv_slot == fill_slot, "pending writes share a slot")

endmodule

`default_nettype wire

// ===== test/lfu_cache_replacement_test.sv =====
// Testbench for lfu_cache_replacement: directed and random items against an LFU predictor
`timescale 1ns / 1ps

module lfu_cache_replacement_test;
  import lfu_pkg::*;

  localparam int NUM_SLOTS = DEF_MAX_ENTRIES;
  localparam int CNT_BITS = 4;
  localparam logic [CNT_BITS-1:0] CNT_MAX = '1;
  localparam logic REQ_LOOKUP = ~REQ_STORE;
  localparam logic [PADDR_W-1:0] CAPACITY_ADDR = {REG_CAPACITY, 2'b00};
  localparam int HOT_CHUNKS = 4;
  localparam int MAX_REPORTS = 10;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  req_t req = '0;
  logic done;
  res_t res;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  lfu_cache_replacement #(
    .MAX_ENTRIES(NUM_SLOTS),
    .COUNT_BITS(CNT_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req(req),
    .done(done),
    .res(res),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic                slot_valid [NUM_SLOTS];
  logic [CHUNK_W-1:0]  slot_chunk [NUM_SLOTS];
  logic [CNT_BITS-1:0] slot_count [NUM_SLOTS];
  logic [STAMP_W-1:0]  slot_stamp [NUM_SLOTS];
  int                  slot_fill = 0;
  logic [STAMP_W-1:0]  stamp_next = '0;
  int                  capacity_now = int'(CAP_RESET);

  res_t               pending_outcomes [$];
  logic [CHUNK_W-1:0] chunk_pool [$];
  int                 send_idle_pct = 0;
  int                 mismatch_count = 0;
  int                 items_sent = 0;
  int                 stores_sent = 0;
  int                 results_seen = 0;
  int                 evict_total = 0;
  int                 sat_total = 0;

  function automatic logic [STAMP_W-1:0] claim_stamp();
    logic [STAMP_W-1:0] s;
    s = stamp_next;
    stamp_next = stamp_next + 1'b1;
    return s;
  endfunction

  function automatic int least_used_slot();
    int best;
    best = -1;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (slot_valid[i] && (best < 0 || slot_count[i] < slot_count[best] ||
          (slot_count[i] == slot_count[best] && slot_stamp[i] < slot_stamp[best])))
        best = i;
    end
    return best;
  endfunction

  function automatic res_t lfu_outcome(req_t r);
    res_t o;
    int slot;
    int victim;
    o = '0;
    slot = -1;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (slot < 0 && slot_valid[i] && slot_chunk[i] == r.chunk_id)
        slot = i;
    end
    if (slot >= 0) begin
      o.hit = 1'b1;
      if (slot_count[slot] != CNT_MAX) begin
        slot_count[slot] = slot_count[slot] + 1'b1;
        slot_stamp[slot] = claim_stamp();
      end else begin
        sat_total++;
      end
    end
    if (r.req_type == REQ_STORE) begin
      if (slot < 0 && slot_fill >= NUM_SLOTS) begin
        victim = least_used_slot();
        o.evicted = 1'b1;
        if (victim < 0 || slot_count[victim] != '0) begin
          o.evicted_chunk = r.chunk_id;
          void'(claim_stamp());
        end else begin
          o.evicted_chunk = slot_chunk[victim];
          slot_chunk[victim] = r.chunk_id;
          slot_count[victim] = '0;
          slot_stamp[victim] = claim_stamp();
        end
      end else begin
        if (slot < 0) begin
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (slot < 0 && !slot_valid[i]) begin
              slot = i;
              slot_valid[i] = 1'b1;
              slot_chunk[i] = r.chunk_id;
              slot_count[i] = '0;
              slot_stamp[i] = claim_stamp();
              slot_fill++;
            end
          end
        end
        if (slot_fill > capacity_now) begin
          victim = least_used_slot();
          if (victim >= 0) begin
            o.evicted = 1'b1;
            o.evicted_chunk = slot_chunk[victim];
            slot_valid[victim] = 1'b0;
            slot_fill--;
          end
        end
      end
    end
    if (o.evicted)
      evict_total++;
    o.full_res = (slot_fill >= capacity_now);
    return o;
  endfunction

  task automatic check_field(string name, logic [CHUNK_W-1:0] want, logic [CHUNK_W-1:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("%0t: %s mismatch: expected %h, got %h", $realtime, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    if (!rst && done) begin
      results_seen++;
      if (pending_outcomes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t: unexpected result %h", $realtime, res);
      end else begin
        want = pending_outcomes.pop_front();
        check_field("hit", want.hit, res.hit);
        check_field("evicted", want.evicted, res.evicted);
        check_field("evicted_chunk", want.evicted_chunk, res.evicted_chunk);
        check_field("full_res", want.full_res, res.full_res);
      end
    end
  end

  task automatic send_item(req_t r);
    int gap;
    res_t outcome;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct)
      gap++;
    if (gap != 0) begin
      start <= 1'b0;
      do @(posedge clk); while (busy);
      repeat (gap - 1) @(posedge clk);
    end
    start <= 1'b1;
    req <= r;
    do @(posedge clk); while (busy);
    items_sent++;
    if (r.req_type == REQ_STORE)
      stores_sent++;
    outcome = lfu_outcome(r);
    pending_outcomes = {pending_outcomes, outcome};
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_outcomes.size() != 0)
      @(posedge clk);
    @(posedge clk);
  endtask

  task automatic apb_access(logic wr, logic [PDATA_W-1:0] wdata, output logic [PDATA_W-1:0] rdata);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= CAPACITY_ADDR;
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_capacity(int value);
    logic [PDATA_W-1:0] data;
    logic [PDATA_W-1:0] rdata;
    drain();
    data = $urandom;
    data[CAP_W-1:0] = value[CAP_W-1:0];
    apb_access(1'b1, data, rdata);
    capacity_now = value;
    apb_access(1'b0, '0, rdata);
    check_field("capacity", capacity_now[CAP_W-1:0], rdata[CAP_W-1:0]);
  endtask

  function automatic logic [CHUNK_W-1:0] random_chunk();
    return {$urandom, $urandom};
  endfunction

  function automatic void refill_pool(int size);
    while (chunk_pool.size() > HOT_CHUNKS)
      void'(chunk_pool.pop_back());
    while (chunk_pool.size() < size)
      chunk_pool = {chunk_pool, random_chunk()};
  endfunction

  function automatic logic [CHUNK_W-1:0] pick_chunk();
    int roll;
    roll = $urandom_range(99);
    if (roll < 25)
      return chunk_pool[$urandom_range(HOT_CHUNKS - 1)];
    if (roll < 90)
      return chunk_pool[$urandom_range(chunk_pool.size() - 1)];
    return random_chunk();
  endfunction

  task automatic run_mix(int count, int store_pct);
    req_t r;
    repeat (count) begin
      r.req_type = ($urandom_range(99) < store_pct) ? REQ_STORE : REQ_LOOKUP;
      r.chunk_id = pick_chunk();
      send_item(r);
    end
  endtask

  task automatic send_one(logic kind, logic [CHUNK_W-1:0] chunk);
    req_t r;
    r.req_type = kind;
    r.chunk_id = chunk;
    send_item(r);
  endtask

  task automatic test_directed();
    logic [PDATA_W-1:0] rdata;
    send_idle_pct = 0;
    apb_access(1'b0, '0, rdata);
    check_field("capacity", capacity_now[CAP_W-1:0], rdata[CAP_W-1:0]);
    send_one(REQ_LOOKUP, '0);
    send_one(REQ_STORE, '0);
    send_one(REQ_STORE, '1);
    send_one(REQ_LOOKUP, '0);
    send_one(REQ_STORE, '1);
    send_one(REQ_LOOKUP, 64'h5555_5555_5555_5555);
    send_one(REQ_STORE, 64'hAAAA_AAAA_AAAA_AAAA);
    send_one(REQ_STORE, '0);
    set_capacity(1);
    send_one(REQ_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAA);
    send_one(REQ_STORE, 64'h5555_5555_5555_5555);
    send_one(REQ_STORE, '0);
    send_one(REQ_STORE, 64'h0123_4567_89AB_CDEF);
    send_one(REQ_STORE, 64'hFEDC_BA98_7654_3210);
    set_capacity(0);
    send_one(REQ_STORE, 64'h8000_0000_0000_0001);
    send_one(REQ_LOOKUP, '0);
    send_one(REQ_STORE, '0);
  endtask

  task automatic test_small_capacity();
    set_capacity(8);
    send_idle_pct = 0;
    refill_pool(24);
    run_mix(250, 50);
  endtask

  task automatic test_table_overflow();
    set_capacity(511);
    send_idle_pct = 65;
    refill_pool(320);
    run_mix(400, 75);
  endtask

  task automatic test_capacity_lowered();
    set_capacity(3);
    send_idle_pct = 0;
    run_mix(250, 80);
  endtask

  task automatic test_full_capacity();
    set_capacity(256);
    send_idle_pct = 10;
    refill_pool(280);
    run_mix(400, 60);
  endtask

  initial begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_valid[i] = 1'b0;
      slot_chunk[i] = '0;
      slot_count[i] = '0;
      slot_stamp[i] = '0;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_small_capacity();
    test_table_overflow();
    test_capacity_lowered();
    test_full_capacity();
    drain();
    repeat (NUM_SLOTS + 8) @(posedge clk);
    $display("Sent %0d items (%0d stores), checked %0d results: %0d evictions, %0d saturated hits",
             items_sent, stores_sent, results_seen, evict_total, sat_total);
    $display("Capacities 256, 1, 0, 8, 511, 3 and 256 with %0d mismatches", mismatch_count);
    if (mismatch_count == 0 && pending_outcomes.size() == 0) begin
      $display("lfu_cache_replacement verification clean");
    end else begin
      $display("lfu_cache_replacement verification failed");
    end
    $finish;
  end

  initial begin
    #(20_000_000);
    $display("lfu_cache_replacement verification failed");
    $finish;
  end

endmodule
